FILE: rtl/core/rfa_pkg.sv
// Shared constants and types for the radiative flux attenuation block.
`timescale 1ns / 1ps
package rfa_pkg;

  localparam int DEPTH_BITS_DEF = 48;

  localparam int COORD_W = 32;
  localparam int FLUX_W  = 31;
  localparam int DIFF_W  = 33;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 34;
  localparam int DIST_W  = 33;
  localparam int Q62_W   = 64;
  localparam int ACC_W   = 128;
  localparam int INC_W   = 49;
  localparam int INC_LSB = 16;
  localparam int EXP_LIM_BIT = 21;
  localparam int R_SHIFT = 41;
  localparam int KDIV_W  = 5;
  localparam int SERIES_TERMS = 16;
  localparam int SQUARINGS = 5;

  localparam logic [Q62_W-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/core/radiative_flux_attenuation_top.sv
// Top level: sequencer and datapath of the Beer-Lambert flux attenuation.
//
//   channel  direction  handshake          word contents
//   in_      input      in_valid/in_stall  first cell, surface flux, face and
//                                         cell centres, absorption
//   out_     output     out_valid/out_stall attenuated cell flux, saturation flag
//
// Each word goes through a square root, then sixteen series terms, each four
// partial products on the shared multiplier and a divide, then five squarings.
// With an optical depth of 32.0 or more the series is skipped.
// Reset is synchronous and active low; all line state resets to zero.
// The input is stalled while a word is in work; a finished word waits in the
// output register, and the next input word is taken meanwhile.
`timescale 1ns / 1ps
module radiative_flux_attenuation_top #(
  parameter int DEPTH_BITS = rfa_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_first_cell,
  input  logic signed [31:0]            in_surface_flux,
  input  logic signed [31:0]            in_face_x,
  input  logic signed [31:0]            in_face_y,
  input  logic signed [31:0]            in_face_z,
  input  logic signed [31:0]            in_cell_x,
  input  logic signed [31:0]            in_cell_y,
  input  logic signed [31:0]            in_cell_z,
  input  logic [31:0]                   in_absorption,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfa_pkg::FLUX_W-1:0]    out_cell_flux,
  output logic                          out_depth_saturated
);

  localparam int SUM_W = ((DEPTH_BITS > rfa_pkg::INC_W) ? DEPTH_BITS : rfa_pkg::INC_W) + 1;
  localparam int Q_LSB = 62;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT_GO, S_SQRT, S_INC_MUL, S_INC_ADD, S_EXP_SEL,
    S_QMUL, S_DIV_GO, S_DIV, S_NEXT, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_HORNER, P_SQUARE, P_FINAL} phase_t;

  state_t state_r;
  phase_t phase_r;

  logic signed [rfa_pkg::COORD_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic [DEPTH_BITS-1:0]              depth_r;
  logic [rfa_pkg::FLUX_W-1:0]         flux_r;
  logic [rfa_pkg::DIFF_W-1:0]         dx_r, dy_r, dz_r;
  logic [31:0]                        absorb_r;
  logic [rfa_pkg::DIST_W-1:0]         dist_r;
  logic [rfa_pkg::ACC_W-1:0]          acc_r;
  logic [2:0]                         cnt_r;
  logic [rfa_pkg::Q62_W-1:0]          qa_r, qb_r;
  logic [rfa_pkg::KDIV_W-1:0]         k_r;
  logic [2:0]                         sqc_r;
  logic                               out_valid_r;
  logic [rfa_pkg::FLUX_W-1:0]         out_flux_r;
  logic                               out_sat_r;

  logic [rfa_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [rfa_pkg::PROD_W-1:0] prod;
  logic                       sq_start, div_start;
  rfa_pkg::unit_stat_t        sq_stat, div_stat;
  logic [rfa_pkg::ROOT_W-1:0] sq_root;
  logic [rfa_pkg::Q62_W-1:0]  div_q;
  logic [rfa_pkg::Q62_W-1:0]  qres;
  logic [rfa_pkg::Q62_W-1:0]  horner_nxt;
  logic                       in_acc;
  logic signed [rfa_pkg::COORD_W-1:0] base_x, base_y, base_z;
  logic [rfa_pkg::DIFF_W-1:0] ax, ay, az;
  logic [rfa_pkg::INC_W-1:0]  inc;
  logic [SUM_W-1:0]           depth_sum;
  logic [DEPTH_BITS-1:0]      depth_nxt;
  logic [2:0]                 pp_idx;
  logic [6:0]                 pp_shift;
  logic [rfa_pkg::ACC_W-1:0]  pp_add;

  function automatic logic [rfa_pkg::DIFF_W-1:0] abs_diff(
    input logic signed [rfa_pkg::COORD_W-1:0] a,
    input logic signed [rfa_pkg::COORD_W-1:0] b
  );
    logic signed [rfa_pkg::DIFF_W-1:0] d;
    d = rfa_pkg::DIFF_W'(a) - rfa_pkg::DIFF_W'(b);
    return d[rfa_pkg::DIFF_W-1] ? rfa_pkg::DIFF_W'(-d) : rfa_pkg::DIFF_W'(d);
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // A first cell measures from the face centre, any other from the last cell.
  assign base_x = in_first_cell ? in_face_x : prev_x_r;
  assign base_y = in_first_cell ? in_face_y : prev_y_r;
  assign base_z = in_first_cell ? in_face_z : prev_z_r;
  assign ax = abs_diff(in_cell_x, base_x);
  assign ay = abs_diff(in_cell_y, base_y);
  assign az = abs_diff(in_cell_z, base_z);

  assign inc       = prod[rfa_pkg::INC_LSB +: rfa_pkg::INC_W];
  assign depth_sum = SUM_W'(depth_r) + SUM_W'(inc);
  assign depth_nxt = (|depth_sum[SUM_W-1:DEPTH_BITS]) ? {DEPTH_BITS{1'b1}}
                                                      : depth_sum[DEPTH_BITS-1:0];

  assign qres       = acc_r[Q_LSB +: rfa_pkg::Q62_W];
  assign horner_nxt = rfa_pkg::ONE_Q62 - div_q;

  // The partial product in the multiplier register was issued in the previous cycle.
  assign pp_idx = cnt_r - 3'd1;
  always_comb begin
    case (pp_idx[1:0])
      2'd0:    pp_shift = 7'd0;
      2'd3:    pp_shift = 7'd64;
      default: pp_shift = 7'd32;
    endcase
    pp_add = rfa_pkg::ACC_W'(prod) << pp_shift;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        case (cnt_r)
          3'd0:    begin mul_a = dx_r; mul_b = dx_r; end
          3'd1:    begin mul_a = dy_r; mul_b = dy_r; end
          3'd2:    begin mul_a = dz_r; mul_b = dz_r; end
          default: begin mul_a = '0;   mul_b = '0;   end
        endcase
      end
      S_INC_MUL: begin
        mul_a = rfa_pkg::MUL_W'(absorb_r);
        mul_b = dist_r;
      end
      S_QMUL: begin
        mul_a = rfa_pkg::MUL_W'(cnt_r[1] ? qa_r[63:32] : qa_r[31:0]);
        mul_b = rfa_pkg::MUL_W'(cnt_r[0] ? qb_r[63:32] : qb_r[31:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_start  = (state_r == S_SQRT_GO);
  assign div_start = (state_r == S_DIV_GO);

  rfa_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  rfa_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r[rfa_pkg::SQ_W-1:0]),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  rfa_divk u_divk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (qres),
    .k     (k_r),
    .stat  (div_stat),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_HORNER;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      depth_r     <= '0;
      flux_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      k_r         <= '0;
      sqc_r       <= '0;
    end else begin
      // In S_OUT the output register is refilled below whenever it drains.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_first_cell) begin
              flux_r  <= in_surface_flux[31] ? '0 : in_surface_flux[rfa_pkg::FLUX_W-1:0];
              depth_r <= '0;
            end
            dx_r     <= ax;
            dy_r     <= ay;
            dz_r     <= az;
            prev_x_r <= in_cell_x;
            prev_y_r <= in_cell_y;
            prev_z_r <= in_cell_z;
            absorb_r <= in_absorption;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r != 3'd0) begin
            acc_r <= acc_r + rfa_pkg::ACC_W'(prod);
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            state_r <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            dist_r  <= sq_root[rfa_pkg::DIST_W-1:0];
            state_r <= S_INC_MUL;
          end
        end
        S_INC_MUL: begin
          state_r <= S_INC_ADD;
        end
        S_INC_ADD: begin
          depth_r <= depth_nxt;
          state_r <= S_EXP_SEL;
        end
        S_EXP_SEL: begin
          acc_r <= '0;
          cnt_r <= '0;
          if (|depth_r[DEPTH_BITS-1:rfa_pkg::EXP_LIM_BIT]) begin
            // Depth of 32.0 or more: the factor is zero.
            qa_r    <= rfa_pkg::Q62_W'(flux_r);
            qb_r    <= '0;
            phase_r <= P_FINAL;
          end else begin
            qa_r    <= {2'b00, depth_r[rfa_pkg::EXP_LIM_BIT-1:0],
                        {rfa_pkg::R_SHIFT{1'b0}}};
            qb_r    <= rfa_pkg::ONE_Q62;
            k_r     <= rfa_pkg::KDIV_W'(rfa_pkg::SERIES_TERMS);
            phase_r <= P_HORNER;
          end
          state_r <= S_QMUL;
        end
        S_QMUL: begin
          if (cnt_r != 3'd0) begin
            acc_r <= acc_r + pp_add;
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            state_r <= (phase_r == P_HORNER) ? S_DIV_GO : S_NEXT;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            qb_r  <= horner_nxt;
            k_r   <= k_r - 1'b1;
            acc_r <= '0;
            cnt_r <= '0;
            if (k_r == rfa_pkg::KDIV_W'(1)) begin
              qa_r    <= horner_nxt;
              sqc_r   <= 3'(rfa_pkg::SQUARINGS);
              phase_r <= P_SQUARE;
            end
            state_r <= S_QMUL;
          end
        end
        S_NEXT: begin
          case (phase_r)
            P_SQUARE: begin
              qb_r  <= qres;
              acc_r <= '0;
              cnt_r <= '0;
              sqc_r <= sqc_r - 3'd1;
              if (sqc_r == 3'd1) begin
                qa_r    <= rfa_pkg::Q62_W'(flux_r);
                phase_r <= P_FINAL;
              end else begin
                qa_r <= qres;
              end
              state_r <= S_QMUL;
            end
            default: begin
              state_r <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_flux_r  <= qres[rfa_pkg::FLUX_W-1:0];
            out_sat_r   <= &depth_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_flux       = out_flux_r;
  assign out_depth_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SQ))
    else $error("accepted word did not start the sequence");

  a_term_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_GO) |-> (k_r != '0))
    else $error("series divide started with a zero term index");

  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (state_r == S_SQRT))
    else $error("square root finished outside its wait state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=>
      (state_r == S_OUT && out_valid_r))
    else $error("pending output word was overwritten");
`endif

endmodule

FILE: rtl/core/rfa_mul.sv
// Shared 33 x 33 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module rfa_mul (
  input  logic                        clk,
  input  logic [rfa_pkg::MUL_W-1:0]   mul_a,
  input  logic [rfa_pkg::MUL_W-1:0]   mul_b,
  output logic [rfa_pkg::PROD_W-1:0]  prod
);

  logic [rfa_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= rfa_pkg::PROD_W'(mul_a) * rfa_pkg::PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

FILE: rtl/core/rfa_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module rfa_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rfa_pkg::SQ_W-1:0]    radicand,
  output rfa_pkg::unit_stat_t         stat,
  output logic [rfa_pkg::ROOT_W-1:0]  root
);

  localparam int RAD_W = 2 * rfa_pkg::ROOT_W;
  localparam int REM_W = rfa_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(rfa_pkg::ROOT_W + 1);

  logic [RAD_W-1:0]           rad_r;
  logic [REM_W-1:0]           rem_r;
  logic [rfa_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;
  logic                       fits;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= RAD_W'(radicand);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(rfa_pkg::ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= fits ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[rfa_pkg::ROOT_W-2:0], fits};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

FILE: rtl/core/rfa_divk.sv
// Divides a 64-bit value by a small term index, eight quotient bits per cycle.
`timescale 1ns / 1ps
module rfa_divk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rfa_pkg::Q62_W-1:0]    x,
  input  logic [rfa_pkg::KDIV_W-1:0]   k,
  output rfa_pkg::unit_stat_t          stat,
  output logic [rfa_pkg::Q62_W-1:0]    q
);

  localparam int BITS_PER_CYC = 8;
  localparam int STEPS = rfa_pkg::Q62_W / BITS_PER_CYC;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = rfa_pkg::KDIV_W - 1;

  logic [rfa_pkg::Q62_W-1:0]  x_r;
  logic [rfa_pkg::KDIV_W-1:0] k_r;
  logic [REM_W-1:0]           rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [rfa_pkg::Q62_W-1:0]  x_step;
  logic [REM_W-1:0]           rem_step;

  // The running word shifts out dividend bits at the top and takes
  // quotient bits in at the bottom.
  always_comb begin
    logic [rfa_pkg::KDIV_W-1:0] t;
    x_step   = x_r;
    rem_step = rem_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t      = {rem_step, x_step[rfa_pkg::Q62_W-1]};
      x_step = {x_step[rfa_pkg::Q62_W-2:0], 1'b0};
      if (t >= k_r) begin
        rem_step  = REM_W'(t - k_r);
        x_step[0] = 1'b1;
      end else begin
        rem_step = t[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        k_r    <= k;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r   <= x_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q         = x_r;

endmodule
